/* rtl/assert_macros.svh */
// assert_macros.svh - shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert an implication, disabled during reset
`define CHK_IMPL(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// assert a next-cycle implication
`define CHK_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/rtfd_pkg.sv */
// ----------------------------------------------------------------------------
// rtfd_pkg
// Shared constants and types of the response time fault detector.
// ----------------------------------------------------------------------------
package rtfd_pkg;
	localparam int MAX_TASKS  = 16;
	localparam int TIME_BITS  = 32;
	localparam int IDX_BITS   = $clog2(MAX_TASKS);
	localparam int CNT_BITS   = 5;
	localparam int ITER_LIMIT = 128;
	localparam int ITER_BITS  = $clog2(ITER_LIMIT + 1);
	localparam int SAT_BITS   = TIME_BITS + 1;
	localparam int IN_BITS    = 2 + 4 + 4 * 32 + 2;
	localparam int IN_BYTES   = (IN_BITS + 7) / 8;
	localparam int OUT_BITS   = 4 + 1 + 1 + 32;
	localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
	localparam logic [SAT_BITS-1:0] CAP = {1'b1, {TIME_BITS{1'b0}}};

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_MARK  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	typedef logic [SAT_BITS-1:0] sat_t;

	// divider handshake between sequencer and divide unit
	typedef struct packed {
		logic start;
		sat_t dividend;
		sat_t divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		sat_t quot;
		logic rem_nz;
	} div_rsp_t;

	function automatic sat_t sat_add(input sat_t a, input sat_t b);
		logic [SAT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s > {1'b0, CAP}) ? CAP : s[SAT_BITS-1:0];
	endfunction
endpackage

/* rtl/rtfd_ram.sv */
// ----------------------------------------------------------------------------
// rtfd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rtfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/rtfd_div.sv */
// ----------------------------------------------------------------------------
// rtfd_div
// Restoring divider, one quotient bit per cycle, for the ceiling term.
// ----------------------------------------------------------------------------
module rtfd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rtfd_pkg::div_req_t req,
	output rtfd_pkg::div_rsp_t rsp
);
	import rtfd_pkg::*;

	localparam int STEP_BITS = $clog2(SAT_BITS + 1);

	sat_t                 quot_q;
	sat_t                 divisor_q;
	logic [SAT_BITS:0]    rem_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SAT_BITS:0]    trial;

	assign trial = {rem_q[SAT_BITS-1:0], quot_q[SAT_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(SAT_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			// shift one dividend bit in, subtract where it fits
			if (trial >= {1'b0, divisor_q}) begin
				rem_q  <= trial - {1'b0, divisor_q};
				quot_q <= {quot_q[SAT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[SAT_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.quot   = quot_q;
	assign rsp.rem_nz = (rem_q != '0);

	`include "assert_macros.svh"
	`CHK_NEXT(a_div_done, arst_n, busy_q && step_q == STEP_BITS'(1) && !req.start,
		done_q && !busy_q, "divider failed to finish")
	`CHK_IMPL(a_div_excl, arst_n, done_q, !busy_q, "divider done while busy")
endmodule

/* rtl/response_time_fault_detector.sv */
// Operation: a write or mark is accepted only in the idle state. A detection run gives one result per task
// from task_index up; for a running task with j higher tasks, setup reads each higher entry
// for its overrun, then each iteration reads every higher entry and divides in the divider,
// up to 128 iterations, before its word is presented; an idle task gets an index-only word.
// Throughput: one word at a time; s_tready stays low until the run's last word leaves.
// Reset: arst_n clears running bits, marks, task_count (to 16) and the control;
// the time tables are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
// response_time_fault_detector
// Fixed-priority response time analysis over a task table, flagging tasks
// whose response time exceeds their period or does not settle by the iteration limit.
// ----------------------------------------------------------------------------
module response_time_fault_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [4:0]                          cfg_wdata,  // task_count
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// operation[1:0], task_index[5:2], period_ticks[37:6], normal_time[69:38],
	// fault_time[101:70], extra_delay[133:102], running[134], mark[135]
	input  logic [rtfd_pkg::IN_BYTES*8-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tested_index[3:0], checked[4], suspicious[5], response_time[37:6]
	output logic [rtfd_pkg::OUT_BYTES*8-1:0]    m_tdata,
	output logic                                m_tuser,    // all_clear
	output logic                                m_tlast
);
	import rtfd_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_TASK  = 11'b00000000010,  // read own entry
		S_OWN   = 11'b00000000100,  // latch own entry
		S_BRD   = 11'b00000001000,  // read higher entry for base
		S_BADD  = 11'b00000010000,  // add overrun of higher entry
		S_ITER  = 11'b00000100000,  // start one iteration
		S_IRD   = 11'b00001000000,  // read higher entry
		S_IDIV  = 11'b00010000000,  // divide R by period and accumulate
		S_IMUL  = 11'b00100000000,  // add own time and compare
		S_EMIT  = 11'b01000000000,  // present result
		S_WAIT  = 11'b10000000000   // latch period and normal time of higher entry
	} state_t;

	state_t                  state_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [MAX_TASKS-1:0]    run_q;
	logic [MAX_TASKS-1:0]    mark_q;
	logic [IDX_BITS:0]       cur_q;      // task under test, at most MAX_TASKS-1
	logic [IDX_BITS:0]       lim_q;      // effective count
	logic [IDX_BITS-1:0]     j_q;
	logic [ITER_BITS-1:0]    it_q;
	sat_t                    r_q, base_q, nxt_q, dn_q, cn_q, p_q, cj_q;

	logic [1:0]              op;
	logic [IDX_BITS-1:0]     idx_in;
	logic                    acc_in, acc_out;
	logic                    ram_we;
	logic [IDX_BITS-1:0]     raddr;
	logic [TIME_BITS-1:0]    per_rd, nor_rd, flt_rd, dly_rd;
	sat_t                    per_e, nor_e, flt_e, ovr_e, prod;
	logic [2*SAT_BITS-1:0]   prod_full;
	div_req_t                dreq;
	div_rsp_t                drsp;
	logic                    clear_w;

	assign op     = s_tdata[1:0];
	assign idx_in = s_tdata[2 +: IDX_BITS];
	assign acc_in = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign ram_we = acc_in && (op == OP_WRITE);

	// read address: task under test, else scan index
	assign raddr = (state_q == S_TASK || state_q == S_EMIT) ? cur_q[IDX_BITS-1:0] : j_q;

	rtfd_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_per (.clk(clk), .we(ram_we),
		.waddr(idx_in), .wdata(s_tdata[6 +: TIME_BITS]), .raddr(raddr), .rdata(per_rd));
	rtfd_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_nor (.clk(clk), .we(ram_we),
		.waddr(idx_in), .wdata(s_tdata[38 +: TIME_BITS]), .raddr(raddr), .rdata(nor_rd));
	rtfd_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_flt (.clk(clk), .we(ram_we),
		.waddr(idx_in), .wdata(s_tdata[70 +: TIME_BITS]), .raddr(raddr), .rdata(flt_rd));
	rtfd_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_dly (.clk(clk), .we(ram_we),
		.waddr(idx_in), .wdata(s_tdata[102 +: TIME_BITS]), .raddr(raddr), .rdata(dly_rd));

	// effective period (zero acts as one) and overrun
	assign per_e = (per_rd == '0) ? sat_t'(1) : {1'b0, per_rd};
	assign nor_e = {1'b0, nor_rd};
	assign flt_e = {1'b0, flt_rd};
	assign ovr_e = (flt_e > nor_e) ? flt_e - nor_e : '0;

	// one multiplier: normal time by ceiling quotient, saturated
	assign prod_full = cj_q * (drsp.quot + sat_t'(drsp.rem_nz));
	assign prod = (prod_full > {{SAT_BITS{1'b0}}, CAP}) ? CAP : prod_full[SAT_BITS-1:0];

	assign dreq.start    = (state_q == S_IDIV) && !drsp.busy && !drsp.done;
	assign dreq.dividend = r_q;
	assign dreq.divisor  = p_q;

	rtfd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// all_clear over tasks in use
	always_comb begin
		clear_w = 1'b1;
		for (int k = 0; k < MAX_TASKS; k++) begin
			if (k < int'(lim_q) && mark_q[k]) clear_w = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= CNT_BITS'(MAX_TASKS);
			run_q    <= '0;
			mark_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			m_tlast  <= 1'b0;
			cur_q    <= '0;
			lim_q    <= '0;
			j_q      <= '0;
			it_q     <= '0;
			r_q      <= '0;
			base_q   <= '0;
			nxt_q    <= '0;
			dn_q     <= '0;
			cn_q     <= '0;
			p_q      <= '0;
			cj_q     <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						if (op == OP_WRITE) begin
							run_q[idx_in] <= s_tdata[134];
						end else if (op == OP_MARK) begin
							mark_q[idx_in] <= s_tdata[135];
						end else if (op == OP_RUN) begin
							cur_q   <= {1'b0, idx_in};
							if (count_q == '0) begin
								lim_q <= (IDX_BITS+1)'(1);
							end else if (count_q > CNT_BITS'(MAX_TASKS)) begin
								lim_q <= (IDX_BITS+1)'(MAX_TASKS);
							end else begin
								lim_q <= (IDX_BITS+1)'(count_q);
							end
							state_q <= S_TASK;
						end
					end
				end
				S_TASK: begin
					if (cur_q >= lim_q) begin
						// empty run: one verdict-only word
						m_tvalid <= 1'b1;
						m_tdata  <= (OUT_BYTES*8)'(cur_q[3:0]);
						m_tuser  <= clear_w;
						m_tlast  <= 1'b1;
						state_q  <= S_EMIT;
					end else if (!run_q[cur_q[IDX_BITS-1:0]]) begin
						m_tvalid <= 1'b1;
						m_tdata  <= (OUT_BYTES*8)'(cur_q[3:0]);
						m_tlast  <= (cur_q + 1'b1 >= lim_q);
						m_tuser  <= (cur_q + 1'b1 >= lim_q) && clear_w;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_OWN;
					end
				end
				S_OWN: begin
					dn_q   <= per_e;
					cn_q   <= nor_e;
					r_q    <= nor_e;
					base_q <= sat_add({1'b0, dly_rd}, ovr_e);
					j_q    <= '0;
					it_q   <= '0;
					state_q <= (cur_q == '0) ? S_ITER : S_BRD;
				end
				S_BRD: state_q <= S_BADD;
				S_BADD: begin
					base_q <= sat_add(base_q, ovr_e);
					if ({1'b0, j_q} + 1'b1 >= cur_q) begin
						j_q     <= '0;
						state_q <= S_ITER;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BRD;
					end
				end
				S_ITER: begin
					if (r_q > dn_q || it_q == ITER_BITS'(ITER_LIMIT)) begin
						mark_q[cur_q[IDX_BITS-1:0]] <= 1'b1;
						m_tvalid <= 1'b1;
						m_tdata  <= (OUT_BYTES*8)'({1'b1, 1'b1, cur_q[3:0]});
						m_tlast  <= (cur_q + 1'b1 >= lim_q);
						m_tuser  <= 1'b0;
						state_q  <= S_EMIT;
					end else begin
						nxt_q <= base_q;
						j_q   <= '0;
						state_q <= (cur_q == '0) ? S_IMUL : S_IRD;
					end
				end
				S_IRD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					p_q  <= per_e;
					cj_q <= nor_e;
					state_q <= S_IDIV;
				end
				S_IDIV: begin
					if (drsp.done) begin
						nxt_q <= sat_add(nxt_q, prod);
						if ({1'b0, j_q} + 1'b1 >= cur_q) begin
							state_q <= S_IMUL;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_IRD;
						end
					end
				end
				S_IMUL: begin
					// close the iteration: add own time and compare
					if (r_q < sat_add(nxt_q, cn_q)) begin
						r_q  <= sat_add(nxt_q, cn_q);
						it_q <= it_q + 1'b1;
						state_q <= S_ITER;
					end else begin
						m_tvalid <= 1'b1;
						m_tdata  <= (OUT_BYTES*8)'({r_q[31:0], 1'b0, 1'b1, cur_q[3:0]});
						m_tlast  <= (cur_q + 1'b1 >= lim_q);
						m_tuser  <= (cur_q + 1'b1 >= lim_q) && clear_w;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (acc_out) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= cur_q + 1'b1;
							state_q <= S_TASK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`CHK_IMPL(a_valid_emit, arst_n, m_tvalid, state_q == S_EMIT, "result outside emit")
	`CHK_IMPL(a_no_accept_busy, arst_n, state_q != S_IDLE, !s_tready, "ready while busy")
	`CHK_NEXT(a_last_idle, arst_n, acc_out && m_tlast, state_q == S_IDLE,
		"run not closed after last word")
endmodule
